>>> src/ksynth_pkg.sv
// Shared constants, types and note table generation for the keyboard wavetable synthesiser.
package ksynth_pkg;

	// Audio and voice configuration.
	localparam int SAMPLE_RATE   = 48000;
	localparam int VOICES        = 8;
	localparam int WAVE_PEAK     = 8388607;
	localparam int MAX_VOLUME    = 12;
	localparam int VOLUME_RESET  = 5;
	localparam int NOTES         = 8;

	// Field widths.
	localparam int CODE_W        = 8;
	localparam int SAMPLE_W      = 25;
	localparam int VOL_W         = 4;
	localparam int MIX_W         = 31;
	localparam int PROD_W        = SAMPLE_W + VOL_W + 1;
	localparam int VIDX_W        = $clog2(NOTES);
	localparam int IN_TDATA_W    = 16;
	localparam int OUT_TDATA_W   = 48;
	localparam int OUT_PAD_W     = OUT_TDATA_W - (MIX_W + NOTES + VOL_W);

	// Request kinds carried on tuser.
	localparam logic MODE_KEY    = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	// PS/2 set-2 scan codes.
	localparam logic [CODE_W-1:0] BREAK_PREFIX = 8'hF0;
	localparam logic [CODE_W-1:0] VOL_UP_KEY   = 8'h79;
	localparam logic [CODE_W-1:0] VOL_DOWN_KEY = 8'h7B;
	localparam logic [CODE_W-1:0] KEY_CODE [NOTES] = '{
		8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h3B, 8'h42, 8'h4B, 8'h4C
	};

	// Note frequencies in thousandths of a hertz.
	localparam longint FREQ_MHZ [NOTES] = '{
		130813, 146832, 164814, 174614, 195998, 220000, 246942, 261626
	};

	// Fixed-point sine constants: pi/2 in Q30 and the Taylor term divisors.
	localparam longint HALF_PI_Q30 = 64'd1686629713;
	localparam longint TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

	typedef int note_tab_t [NOTES];

	function automatic note_tab_t len_tab();
		note_tab_t tab;
		for (int v = 0; v < NOTES; v++) begin
			tab[v] = int'((longint'(SAMPLE_RATE) * 1000) / FREQ_MHZ[v]);
		end
		return tab;
	endfunction

	localparam note_tab_t ROM_LEN = len_tab();

	function automatic note_tab_t base_tab();
		note_tab_t tab;
		int        acc;
		acc = 0;
		for (int v = 0; v < NOTES; v++) begin
			tab[v] = acc;
			acc    = acc + ROM_LEN[v];
		end
		return tab;
	endfunction

	localparam note_tab_t ROM_BASE = base_tab();
	localparam int ROM_DEPTH = ROM_BASE[NOTES-1] + ROM_LEN[NOTES-1];
	localparam int ROM_AW    = $clog2(ROM_DEPTH);
	localparam int PHASE_W   = $clog2(ROM_LEN[0]);

	// Quarter-wave folded sine, Taylor series through the thirteenth power.
	function automatic longint sine_at(longint k);
		longint m, q, r, x, x2, term, sum, val;
		m = (k % SAMPLE_RATE) * 4;
		q = m / SAMPLE_RATE;
		r = m - q * SAMPLE_RATE;
		if (q[0]) begin
			r = SAMPLE_RATE - r;
		end
		x    = (HALF_PI_Q30 * r + SAMPLE_RATE / 2) / SAMPLE_RATE;
		x2   = (x * x) >>> 30;
		term = x;
		sum  = x;
		for (int j = 1; j <= 6; j++) begin
			term = ((term * x2) >>> 30) / TAYLOR_DIV[j-1];
			if (j % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		val = (sum * WAVE_PEAK + (64'sd1 <<< 29)) >>> 30;
		if (val > WAVE_PEAK) begin
			val = WAVE_PEAK;
		end
		return (q >= 2) ? -val : val;
	endfunction

	typedef logic signed [SAMPLE_W-1:0] rom_tab_t [ROM_DEPTH];

	// One period per note, linearly interpolated between sine table points.
	function automatic rom_tab_t build_rom();
		rom_tab_t rom;
		longint   p, i, w, a, b, val;
		for (int v = 0; v < NOTES; v++) begin
			for (int t = 0; t < ROM_LEN[v]; t++) begin
				p   = FREQ_MHZ[v] * t;
				i   = (p / 1000) % SAMPLE_RATE;
				w   = p % 1000;
				a   = sine_at(i);
				b   = sine_at((i + 1) % SAMPLE_RATE);
				val = (a * (1000 - w) + b * w) / 1000;
				rom[ROM_BASE[v] + t] = SAMPLE_W'(val);
			end
		end
		return rom;
	endfunction

	localparam rom_tab_t NOTE_ROM = build_rom();

	// Controller to datapath commands.
	typedef struct packed {
		logic              load;
		logic              key_apply;
		logic              read;
		logic [VIDX_W-1:0] vidx;
		logic              emit;
	} ctrl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

>>> src/ksynth_dp.sv
// Datapath: voice state, note ROM, multiply-accumulate pipeline and output register.
module ksynth_dp #(
	parameter int VOICES     = ksynth_pkg::VOICES,
	parameter int MAX_VOLUME = ksynth_pkg::MAX_VOLUME
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [ksynth_pkg::CODE_W-1:0]          in_code,
	input  logic                                   in_codec,
	input  logic                                   out_ready,
	input  ksynth_pkg::ctrl_cmd_t                  cmd,
	output ksynth_pkg::dp_status_t                 status,
	output logic                                   out_valid,
	output logic signed [ksynth_pkg::MIX_W-1:0]    out_mixed,
	output logic [ksynth_pkg::NOTES-1:0]           out_voices,
	output logic [ksynth_pkg::VOL_W-1:0]           out_volume
);

	localparam int NOTES   = ksynth_pkg::NOTES;
	localparam int PHASE_W = ksynth_pkg::PHASE_W;
	localparam int VOL_W   = ksynth_pkg::VOL_W;
	localparam int ROM_AW  = ksynth_pkg::ROM_AW;
	localparam int MIX_W   = ksynth_pkg::MIX_W;
	localparam int PROD_W  = ksynth_pkg::PROD_W;
	localparam int VIDX_W  = ksynth_pkg::VIDX_W;

	// Request held for the duration of its processing.
	logic [ksynth_pkg::CODE_W-1:0] code_q;
	logic                          codec_q;

	logic [NOTES-1:0]   active_q;
	logic [PHASE_W-1:0] phase_q [NOTES];
	logic [VOL_W-1:0]   volume_q;
	logic               release_q;

	logic [NOTES-1:0]   key_hit;
	logic [VOL_W-1:0]   vol_up;
	logic [VOL_W-1:0]   vol_down;
	logic [PHASE_W-1:0] phase_sel;
	logic [PHASE_W:0]   phase_inc;
	logic [PHASE_W-1:0] phase_next;
	logic [ROM_AW-1:0]  rom_addr;

	logic signed [ksynth_pkg::SAMPLE_W-1:0] rd_s1;
	logic                                   v_s1;
	logic signed [PROD_W-1:0]               prod_s2;
	logic                                   v_s2;
	logic signed [MIX_W-1:0]                acc_q;
	logic                                   out_valid_q;

	always_comb begin
		for (int v = 0; v < NOTES; v++) begin
			key_hit[v] = (code_q == ksynth_pkg::KEY_CODE[v]) && (v < VOICES);
		end
	end

	assign vol_up = (({1'b0, volume_q} + (VOL_W+1)'(2)) > (VOL_W+1)'(MAX_VOLUME))
		? VOL_W'(MAX_VOLUME) : volume_q + VOL_W'(2);
	assign vol_down = (volume_q < VOL_W'(2)) ? '0 : volume_q - VOL_W'(2);

	// The selected voice's phase steps and wraps at the end of its period.
	assign phase_sel  = phase_q[cmd.vidx];
	assign phase_inc  = {1'b0, phase_sel} + (PHASE_W+1)'(1);
	assign phase_next = (phase_inc >= (PHASE_W+1)'(ksynth_pkg::ROM_LEN[cmd.vidx]))
		? '0 : phase_inc[PHASE_W-1:0];
	assign rom_addr   = ROM_AW'(ksynth_pkg::ROM_BASE[cmd.vidx]) + ROM_AW'(phase_sel);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q  <= in_code;
			codec_q <= in_codec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			volume_q  <= VOL_W'(ksynth_pkg::VOLUME_RESET);
			release_q <= 1'b0;
			for (int v = 0; v < NOTES; v++) begin
				phase_q[v] <= '0;
			end
		end else begin
			if (cmd.key_apply) begin
				if (release_q) begin
					release_q <= 1'b0;
					active_q  <= active_q & ~key_hit;
				end else if (code_q == ksynth_pkg::BREAK_PREFIX) begin
					release_q <= 1'b1;
				end else begin
					active_q <= active_q | key_hit;
					if (code_q == ksynth_pkg::VOL_UP_KEY) begin
						volume_q <= vol_up;
					end else if (code_q == ksynth_pkg::VOL_DOWN_KEY) begin
						volume_q <= vol_down;
					end
				end
			end
			for (int v = 0; v < NOTES; v++) begin
				if (cmd.key_apply && release_q && key_hit[v]) begin
					phase_q[v] <= '0;
				end else if (cmd.read && codec_q && active_q[v]
						&& (cmd.vidx == VIDX_W'(v))) begin
					phase_q[v] <= phase_next;
				end
			end
		end
	end

	// Pipeline: ROM read, multiply by volume, accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.read && active_q[cmd.vidx];
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1   <= ksynth_pkg::NOTE_ROM[rom_addr];
		prod_s2 <= PROD_W'($signed({1'b0, volume_q})) * PROD_W'(rd_s1);
		if (cmd.load) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + MIX_W'(prod_s2);
		end
	end

	// Output register; a new result is loaded once the previous one has gone.
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && status.out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && status.out_free) begin
			out_mixed  <= acc_q;
			out_voices <= active_q;
			out_volume <= volume_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/ksynth_ctrl.sv
// Controller: sequences key updates and the per-voice walk for each sample tick.
module ksynth_ctrl #(
	parameter int VOICES = ksynth_pkg::VOICES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_mode,
	input  ksynth_pkg::dp_status_t status,
	output logic                   in_ready,
	output ksynth_pkg::ctrl_cmd_t  cmd
);

	localparam int VIDX_W = ksynth_pkg::VIDX_W;
	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_READ,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [VIDX_W-1:0] vidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vidx_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (in_mode == ksynth_pkg::MODE_TICK) ? ST_READ : ST_KEY;
						vidx_q  <= '0;
					end
				end
				ST_KEY: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					if (vidx_q == LAST_VOICE) begin
						state_q <= ST_DRAIN1;
					end else begin
						vidx_q <= vidx_q + VIDX_W'(1);
					end
				end
				ST_DRAIN1: begin
					state_q <= ST_DRAIN2;
				end
				ST_DRAIN2: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.key_apply = (state_q == ST_KEY);
		cmd.read      = (state_q == ST_READ);
		cmd.vidx      = vidx_q;
		cmd.emit      = (state_q == ST_EMIT);
	end

endmodule

>>> src/keyboard_wavetable_synth_top.sv
// Top level of the eight-voice keyboard wavetable synthesiser.
//
// The input channel carries two kinds of request, told apart by s_axis_tuser:
// a PS/2 set-2 scan-code byte (tuser low) or a sample tick (tuser high).
// A scan-code byte produces no result; it turns a note voice on, releases one
// after a break prefix, or steps the shared volume. A tick produces exactly one
// result on the output channel: the sum of volume times the note ROM sample of
// every sounding voice, the voice-on mask and the volume in force.
// A scan-code byte is accepted in the idle state and applied in the key state.
// A tick is accepted, then walks the voices one by one through the single
// note ROM read port, drains the multiply-accumulate pipeline and loads the
// output register, from which the result is offered on the output channel.
// The block takes one request at a time; s_axis_tready is high while idle.
// The output register holds a finished result while the receiver stalls;
// further scan-code bytes are still taken, but the next tick waits in its
// final cycle until the held result has been taken.
// Reset silences every voice, zeroes all phases, sets the volume to five and
// clears any pending break prefix. The note ROM is a fixed table.
module keyboard_wavetable_synth_top #(
	parameter int VOICES     = ksynth_pkg::VOICES,
	parameter int MAX_VOLUME = ksynth_pkg::MAX_VOLUME
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Bits from the lowest up: scan_code[7:0], codec_accepted[8], zero padding.
	input  logic [ksynth_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// Bit 0: mode (0 scan-code byte, 1 sample tick).
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Bits from the lowest up: mixed_sample[30:0], voices_on[38:31],
	// volume_now[42:39], zero padding.
	output logic [ksynth_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	ksynth_pkg::ctrl_cmd_t  cmd;
	ksynth_pkg::dp_status_t status;

	logic signed [ksynth_pkg::MIX_W-1:0] mixed;
	logic [ksynth_pkg::NOTES-1:0]        voices;
	logic [ksynth_pkg::VOL_W-1:0]        volume;

	// The controller decides when each request is taken and walks the voices.
	ksynth_ctrl #(
		.VOICES (VOICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.status   (status),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	// The datapath holds the voice state, the ROM and the output register.
	ksynth_dp #(
		.VOICES     (VOICES),
		.MAX_VOLUME (MAX_VOLUME)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_code    (s_axis_tdata[ksynth_pkg::CODE_W-1:0]),
		.in_codec   (s_axis_tdata[ksynth_pkg::CODE_W]),
		.out_ready  (m_axis_tready),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.out_mixed  (mixed),
		.out_voices (voices),
		.out_volume (volume)
	);

	assign m_axis_tdata = {{ksynth_pkg::OUT_PAD_W{1'b0}}, volume, voices, mixed};

endmodule

>>> bench/tb_keyboard_wavetable_synth_top.sv
// Self-checking testbench for the keyboard wavetable synthesiser with its own voice predictor.
`timescale 1ns / 100ps

module tb_keyboard_wavetable_synth_top;

	localparam int CODE_W       = ksynth_pkg::CODE_W;
	localparam int NOTES        = ksynth_pkg::NOTES;
	localparam int VOICES       = ksynth_pkg::VOICES;
	localparam int MIX_W        = ksynth_pkg::MIX_W;
	localparam int VOL_W        = ksynth_pkg::VOL_W;
	localparam int IN_TDATA_W   = ksynth_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W  = ksynth_pkg::OUT_TDATA_W;
	localparam int SAMPLE_RATE  = ksynth_pkg::SAMPLE_RATE;
	localparam int WAVE_PEAK    = ksynth_pkg::WAVE_PEAK;
	localparam int MAX_VOLUME   = ksynth_pkg::MAX_VOLUME;
	localparam int VOLUME_RESET = ksynth_pkg::VOLUME_RESET;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 4;
	localparam int LIMIT_CYCLES   = 400000;
	localparam int RANDOM_ITEMS   = 900;
	// Random requests before this index draw no release or break sequences, so that held
	// voices run long enough for the shorter note periods to wrap.
	localparam int OPEN_ITEMS     = 700;
	localparam int CALM_FIRST     = 700;
	localparam int CALM_LAST      = 850;
	localparam int RX_HOLD_AT     = 3000;
	localparam int RX_HOLD_LEN    = 600;
	localparam int RX_CALM_FIRST  = 5000;
	localparam int RX_CALM_LAST   = 7000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int TONE_COLS      = 384;
	localparam int PLAN_ROWS      = 25;

	// Bytes that are neither note keys nor control keys.
	localparam logic [CODE_W-1:0] STRAY_BYTE = 8'hFF;

	// pi/2 in Q30 and the note pitches in thousandths of a hertz.
	localparam longint QUARTER_TURN_Q30 = 1686629713;
	localparam longint TONE_MHZ [NOTES] = '{
		130813, 146832, 164814, 174614, 195998, 220000, 246942, 261626
	};

	typedef struct packed {
		logic [MIX_W-1:0]  mix;
		logic [NOTES-1:0]  on;
		logic [VOL_W-1:0]  vol;
	} mix_result_t;

	typedef struct packed {
		logic              mode;
		logic [CODE_W-1:0] code;
		logic              acc;
		logic              typed;
		mix_result_t       want;
	} plan_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
	logic                     s_axis_tuser = ksynth_pkg::MODE_KEY;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]   m_axis_tdata;

	// Predictor state: the wave table, the voices and the shared volume.
	int                       tone_wave [NOTES][TONE_COLS];
	int                       tone_len [NOTES];
	int                       tone_phase [NOTES] = '{default: 0};
	logic [NOTES-1:0]         tone_on = '0;
	int                       tone_vol = VOLUME_RESET;
	logic                     break_armed = 1'b0;

	mix_result_t              pending_mix [$];
	int                       mismatch_count = 0;
	logic                     sender_calm = 1'b0;
	int                       cycles_run = 0;
	int                       rx_cycles = 0;
	int                       rx_hold_left = 0;

	// Directed requests. Results are typed in where they follow at once from
	// reset or from a volume stepped down to zero; the rest come from the predictor.
	plan_row_t plan [PLAN_ROWS] = '{
		'{ksynth_pkg::MODE_TICK, STRAY_BYTE, 1'b1, 1'b1, '{31'd0, 8'h00, 4'(VOLUME_RESET)}},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::VOL_DOWN_KEY, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::VOL_DOWN_KEY, 1'b1, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::VOL_DOWN_KEY, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_TICK, STRAY_BYTE, 1'b0, 1'b1, '{31'd0, 8'h00, 4'd0}},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::KEY_CODE[0], 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::KEY_CODE[0], 1'b1, 1'b0, '0},
		'{ksynth_pkg::MODE_TICK, ksynth_pkg::KEY_CODE[0], 1'b1, 1'b1, '{31'd0, 8'h01, 4'd0}},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::VOL_UP_KEY, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::VOL_UP_KEY, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::VOL_UP_KEY, 1'b1, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::VOL_UP_KEY, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_TICK, ksynth_pkg::BREAK_PREFIX, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::KEY_CODE[7], 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  STRAY_BYTE, 1'b1, 1'b0, '0},
		'{ksynth_pkg::MODE_TICK, 8'h00, 1'b1, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::BREAK_PREFIX, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::KEY_CODE[0], 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_TICK, 8'h00, 1'b1, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::BREAK_PREFIX, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::BREAK_PREFIX, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::KEY_CODE[1], 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::BREAK_PREFIX, 1'b1, 1'b0, '0},
		'{ksynth_pkg::MODE_KEY,  ksynth_pkg::VOL_UP_KEY, 1'b0, 1'b0, '0},
		'{ksynth_pkg::MODE_TICK, 8'h00, 1'b1, 1'b0, '0}
	};

	keyboard_wavetable_synth_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// One point of the sine, scaled to the wave peak. The angle is folded into
	// the first quadrant and the series runs to the thirteenth power in Q30.
	function automatic longint sine_point(longint k);
		longint m, q, r, x, x2, term, total, val;
		m = (k % SAMPLE_RATE) * 4;
		q = m / SAMPLE_RATE;
		r = m - q * SAMPLE_RATE;
		if (q % 2 == 1) begin
			r = SAMPLE_RATE - r;
		end
		x     = (QUARTER_TURN_Q30 * r + SAMPLE_RATE / 2) / SAMPLE_RATE;
		x2    = (x * x) >>> 30;
		term  = x;
		total = x;
		for (int j = 1; j <= 6; j++) begin
			term = ((term * x2) >>> 30) / ((2 * j) * (2 * j + 1));
			if (j % 2 == 1) begin
				total = total - term;
			end else begin
				total = total + term;
			end
		end
		if (total < 0) begin
			total = 0;
		end
		val = (total * WAVE_PEAK + (longint'(1) <<< 29)) >>> 30;
		if (val > WAVE_PEAK) begin
			val = WAVE_PEAK;
		end
		return (q >= 2) ? -val : val;
	endfunction

	// Each note holds one period, interpolated between neighbouring sine
	// points with a weight in thousandths.
	initial begin : fill_wave_table
		longint p, i, w, a, b;
		for (int v = 0; v < NOTES; v++) begin
			tone_len[v] = int'((longint'(SAMPLE_RATE) * 1000) / TONE_MHZ[v]);
			for (int t = 0; t < tone_len[v]; t++) begin
				p = TONE_MHZ[v] * t;
				i = (p / 1000) % SAMPLE_RATE;
				w = p % 1000;
				a = sine_point(i);
				b = sine_point((i + 1) % SAMPLE_RATE);
				tone_wave[v][t] = int'((a * (1000 - w) + b * w) / 1000);
			end
		end
	end

	// Advances the predicted voices by one accepted request. A tick leaves its
	// expected result in the queue; a typed-in result replaces the predicted one.
	task automatic voice_step(input logic mode, input logic [CODE_W-1:0] code,
			input logic acc, input logic typed, input mix_result_t typed_want);
		longint      total;
		mix_result_t res;
		if (mode == ksynth_pkg::MODE_KEY) begin
			if (break_armed) begin
				// The byte after a break prefix is the released key, whatever it is.
				break_armed = 1'b0;
				for (int v = 0; v < NOTES; v++) begin
					if (v < VOICES && code == ksynth_pkg::KEY_CODE[v]) begin
						tone_on[v]    = 1'b0;
						tone_phase[v] = 0;
					end
				end
			end else if (code == ksynth_pkg::BREAK_PREFIX) begin
				break_armed = 1'b1;
			end else begin
				for (int v = 0; v < NOTES; v++) begin
					if (v < VOICES && code == ksynth_pkg::KEY_CODE[v]) begin
						tone_on[v] = 1'b1;
					end
				end
				if (code == ksynth_pkg::VOL_UP_KEY) begin
					tone_vol = (tone_vol + 2 > MAX_VOLUME) ? MAX_VOLUME : tone_vol + 2;
				end
				if (code == ksynth_pkg::VOL_DOWN_KEY) begin
					tone_vol = (tone_vol < 2) ? 0 : tone_vol - 2;
				end
			end
		end else begin
			total = 0;
			for (int v = 0; v < NOTES; v++) begin
				if (tone_on[v]) begin
					total = total + longint'(tone_vol) * tone_wave[v][tone_phase[v]];
				end
			end
			// Phases move only when the codec took the sample.
			if (acc) begin
				for (int v = 0; v < NOTES; v++) begin
					if (tone_on[v]) begin
						tone_phase[v] = (tone_phase[v] + 1 >= tone_len[v]) ? 0 : tone_phase[v] + 1;
					end
				end
			end
			res.mix = total[MIX_W-1:0];
			res.on  = tone_on;
			res.vol = VOL_W'(tone_vol);
			pending_mix.push_back(typed ? typed_want : res);
		end
	endtask

	// Offers one request, after a random idle gap unless the sender is calm, and holds it until taken.
	task automatic send_request(input logic mode, input logic [CODE_W-1:0] code,
			input logic acc, input logic typed = 1'b0, input mix_result_t typed_want = '0);
		while (!sender_calm && $urandom_range(0, 99) < 25) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= IN_TDATA_W'({acc, code});
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		voice_step(mode, code, acc, typed, typed_want);
	endtask

	task automatic report_mismatch(input string what, input logic [MIX_W-1:0] got,
			input logic [MIX_W-1:0] want);
		mismatch_count++;
		$display("%0d ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Stimulus: reset, the directed table, then the random requests.
	initial begin : drive_requests
		int pick;
		int v;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (int n = 0; n < PLAN_ROWS; n++) begin
			send_request(plan[n].mode, plan[n].code, plan[n].acc, plan[n].typed, plan[n].want);
		end

		// Mostly ticks and note presses with random content; releases, volume
		// steps, stray bytes and broken break sequences make up the rest.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sender_calm = (n >= CALM_FIRST && n < CALM_LAST);
			pick = $urandom_range(0, 99);
			v    = $urandom_range(0, NOTES - 1);
			if (pick < 52) begin
				send_request(ksynth_pkg::MODE_TICK, CODE_W'($urandom),
					$urandom_range(0, 99) < 85);
			end else if (pick < 70 || (pick < 84 && n < OPEN_ITEMS)) begin
				send_request(ksynth_pkg::MODE_KEY, ksynth_pkg::KEY_CODE[v], 1'($urandom));
			end else if (pick < 78) begin
				send_request(ksynth_pkg::MODE_KEY, ksynth_pkg::BREAK_PREFIX, 1'($urandom));
				send_request(ksynth_pkg::MODE_KEY, ksynth_pkg::KEY_CODE[v], 1'($urandom));
			end else if (pick < 84) begin
				send_request(ksynth_pkg::MODE_KEY, ksynth_pkg::BREAK_PREFIX, 1'($urandom));
				send_request(ksynth_pkg::MODE_KEY, CODE_W'($urandom_range(0, 255)),
					1'($urandom));
			end else if (pick < 92) begin
				send_request(ksynth_pkg::MODE_KEY,
					(pick % 2 == 1) ? ksynth_pkg::VOL_UP_KEY : ksynth_pkg::VOL_DOWN_KEY,
					1'($urandom));
			end else begin
				send_request(ksynth_pkg::MODE_KEY, CODE_W'($urandom_range(0, 255)),
					1'($urandom));
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_mix.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Receiver: random stalls, one long hold-off that backs the block up while
	// requests keep coming, and a stretch that never stalls.
	always @(posedge clk) begin
		rx_cycles = rx_cycles + 1;
		if (rx_hold_left > 0) begin
			rx_hold_left = rx_hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_cycles == RX_HOLD_AT) begin
			rx_hold_left = RX_HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else if (rx_cycles >= RX_CALM_FIRST && rx_cycles < RX_CALM_LAST) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= 25);
		end
	end

	// Every result taken is compared field by field with the oldest expectation.
	always @(posedge clk) begin : check_results
		mix_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_mix.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[MIX_W-1:0], '0);
			end else begin
				want = pending_mix.pop_front();
				if (m_axis_tdata[MIX_W-1:0] !== want.mix) begin
					report_mismatch("mixed_sample", m_axis_tdata[MIX_W-1:0], want.mix);
				end
				if (m_axis_tdata[MIX_W+NOTES-1:MIX_W] !== want.on) begin
					report_mismatch("voices_on", MIX_W'(m_axis_tdata[MIX_W+NOTES-1:MIX_W]),
						MIX_W'(want.on));
				end
				if (m_axis_tdata[MIX_W+NOTES+VOL_W-1:MIX_W+NOTES] !== want.vol) begin
					report_mismatch("volume_now",
						MIX_W'(m_axis_tdata[MIX_W+NOTES+VOL_W-1:MIX_W+NOTES]), MIX_W'(want.vol));
				end
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycles_run = cycles_run + 1;
		if (cycles_run >= LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
